[hw/rtl/taag_pkg.sv]
package taag_pkg;

	localparam int MAX_TILE_DIM = 8;
	localparam int ADDR_BITS    = 48;

	localparam int DIM_W    = 4;
	localparam int CNT_W    = (MAX_TILE_DIM > 1) ? $clog2(MAX_TILE_DIM) : 1;
	localparam int STRIDE_W = 16;
	localparam int EB_W     = 7;
	localparam int MAX_EB   = 64;
	localparam int REG_W    = 2;
	localparam int RS_W     = STRIDE_W + EB_W;
	localparam int NUM_TREGS = 3;

	localparam int IN_BASE_LSB   = 0;
	localparam int IN_W_LSB      = IN_BASE_LSB + ADDR_BITS;
	localparam int IN_H_LSB      = IN_W_LSB + DIM_W;
	localparam int IN_STRIDE_LSB = IN_H_LSB + DIM_W;
	localparam int IN_EB_LSB     = IN_STRIDE_LSB + STRIDE_W;
	localparam int IN_TREG_LSB   = IN_EB_LSB + EB_W;
	localparam int IN_MA_LSB     = IN_TREG_LSB + REG_W;
	localparam int IN_MB_LSB     = IN_MA_LSB + REG_W;
	localparam int IN_MC_LSB     = IN_MB_LSB + REG_W;
	localparam int IN_FIELDS_W   = IN_MC_LSB + REG_W;
	localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_USER_W     = 2;

	localparam int OUT_FIELDS_W = ADDR_BITS + EB_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_USER_W   = 4;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] CFG_CHECK_EN = 2'd0;
	localparam logic [1:0] CFG_ROWS_M   = 2'd1;
	localparam logic [1:0] CFG_COLS_N   = 2'd2;
	localparam logic [1:0] CFG_INNER_K  = 2'd3;

	localparam logic [REG_W-1:0] TREG_A = REG_W'(0);
	localparam logic [REG_W-1:0] TREG_B = REG_W'(1);
	localparam logic [REG_W-1:0] TREG_C = REG_W'(2);

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_STORE,
		OP_PREFETCH,
		OP_MAC
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SHAPE,
		ST_MAC_SHAPE
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_PREP,
		S_WALK
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
	} walk_ctl_t;

	typedef struct packed {
		logic last_elem;
	} walk_stat_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_W'(MAX_TILE_DIM)) ? DIM_W'(MAX_TILE_DIM) : v;
	endfunction

endpackage

[hw/rtl/taag_walker.sv]
module taag_walker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  taag_pkg::walk_ctl_t             ctl,
	input  logic [taag_pkg::ADDR_BITS-1:0]  base,
	input  logic [taag_pkg::EB_W-1:0]       eb,
	input  logic [taag_pkg::RS_W-1:0]       row_step,
	input  logic [taag_pkg::DIM_W-1:0]      tile_w,
	input  logic [taag_pkg::DIM_W-1:0]      tile_h,
	output logic [taag_pkg::ADDR_BITS-1:0]  addr,
	output taag_pkg::walk_stat_t            stat
);
	import taag_pkg::*;

	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] row_base_q;
	logic [CNT_W-1:0]     col_q;
	logic [CNT_W-1:0]     row_q;
	logic [CNT_W-1:0]     col_max;
	logic [CNT_W-1:0]     row_max;
	logic                 col_end;
	logic [ADDR_BITS-1:0] opa;
	logic [ADDR_BITS-1:0] opb;
	logic [ADDR_BITS-1:0] sum;

	assign col_max = CNT_W'(DIM_W'(tile_w - 1'b1));
	assign row_max = CNT_W'(DIM_W'(tile_h - 1'b1));
	assign col_end = (col_q == col_max);

	// single adder: next element in the row, or next row start
	assign opa = col_end ? row_base_q : addr_q;
	assign opb = col_end ? ADDR_BITS'(row_step) : ADDR_BITS'(eb);
	assign sum = opa + opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.start) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.step) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			addr_q     <= base;
			row_base_q <= base;
		end else if (ctl.step) begin
			addr_q <= sum;
			if (col_end) begin
				row_base_q <= sum;
			end
		end
	end

	assign addr           = addr_q;
	assign stat.last_elem = col_end && (row_q == row_max);

endmodule

[hw/rtl/tile_access_address_generator.sv]
// Tile access address generator.
// Input channel s_axis_*: one tile instruction per beat (opcode in tuser).
// Output channel m_axis_*: one beat per element access, or a single status
// beat for a multiply-accumulate, a failed shape check or an empty tile.
// tlast marks the final beat of each instruction.
// Configuration: APB port, registers check_enable, rows_m, cols_n, inner_k
// at byte addresses 0, 4, 8, 12; write only while the block is idle.
// Timing: accept beat, then the decode state S_PREP (for a multiply-accumulate
// S_RD_A and S_RD_B come before it, as it reads its three tile registers one
// per cycle), then one output beat per cycle from the shared address adder
// while the receiver takes them.
// s_axis_tready is high only while idle. The final beat sits in the output
// register, so the next instruction is taken while it waits.
// When m_axis_tready is low the output beat holds and the walk pauses.
// Reset: tile register shapes cleared, configuration at its defaults
// (checks off, M=N=K=8), no beat pending.
module tile_access_address_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// base_address, width, height, row_stride, element_bytes,
	// tile_reg, mul_reg_a, mul_reg_b, mul_reg_c, zero pad
	input  logic [taag_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// opcode
	input  logic [taag_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// access_address, access_bytes, zero pad
	output logic [taag_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// is_write, is_access, status
	output logic [taag_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [taag_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [taag_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [taag_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import taag_pkg::*;

	state_t state_q, state_d;

	logic             check_en_q;
	logic [DIM_W-1:0] rows_m_q;
	logic [DIM_W-1:0] cols_n_q;
	logic [DIM_W-1:0] inner_k_q;

	logic [DIM_W-1:0] reg_w_q [NUM_TREGS];
	logic [DIM_W-1:0] reg_h_q [NUM_TREGS];

	op_t                  op_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [DIM_W-1:0]     w_q;
	logic [DIM_W-1:0]     h_q;
	logic [STRIDE_W-1:0]  stride_q;
	logic [EB_W-1:0]      eb_q;
	logic [REG_W-1:0]     treg_q;
	logic [REG_W-1:0]     ma_q;
	logic [REG_W-1:0]     mb_q;
	logic [REG_W-1:0]     mc_q;
	logic [RS_W-1:0]      row_step_q;
	logic [DIM_W-1:0]     aw_q, ah_q, bw_q, bh_q;

	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] out_addr_q;
	logic [EB_W-1:0]      out_bytes_q;
	logic                 out_wr_q;
	logic                 out_acc_q;
	status_t              out_st_q;
	logic                 out_last_q;

	logic [REG_W-1:0] rd_idx;
	logic [DIM_W-1:0] rd_w, rd_h;
	logic [DIM_W-1:0] exp_w, exp_h;
	logic             ls_bad, mac_bad, status_item, rec_ok;
	logic             rec_en, out_load, out_free, in_acc, cfg_wr;
	logic [EB_W-1:0]  in_eb;
	status_t          st_code;

	walk_ctl_t            wctl;
	walk_stat_t           wstat;
	logic [ADDR_BITS-1:0] walk_addr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_en_q <= 1'b0;
			rows_m_q   <= DIM_W'(8);
			cols_n_q   <= DIM_W'(8);
			inner_k_q  <= DIM_W'(8);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				CFG_CHECK_EN: check_en_q <= pwdata[0];
				CFG_ROWS_M:   rows_m_q   <= pwdata[DIM_W-1:0];
				CFG_COLS_N:   cols_n_q   <= pwdata[DIM_W-1:0];
				CFG_INNER_K:  inner_k_q  <= pwdata[DIM_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			CFG_CHECK_EN: prdata = CFG_DATA_W'(check_en_q);
			CFG_ROWS_M:   prdata = CFG_DATA_W'(rows_m_q);
			CFG_COLS_N:   prdata = CFG_DATA_W'(cols_n_q);
			CFG_INNER_K:  prdata = CFG_DATA_W'(inner_k_q);
		endcase
	end

	assign in_eb = s_axis_tdata[IN_EB_LSB +: EB_W];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= op_t'(s_axis_tuser[1:0]);
			base_q   <= s_axis_tdata[IN_BASE_LSB +: ADDR_BITS];
			w_q      <= sat_dim(s_axis_tdata[IN_W_LSB +: DIM_W]);
			h_q      <= sat_dim(s_axis_tdata[IN_H_LSB +: DIM_W]);
			stride_q <= s_axis_tdata[IN_STRIDE_LSB +: STRIDE_W];
			eb_q     <= (in_eb > EB_W'(MAX_EB)) ? EB_W'(MAX_EB) : in_eb;
			treg_q   <= s_axis_tdata[IN_TREG_LSB +: REG_W];
			ma_q     <= s_axis_tdata[IN_MA_LSB +: REG_W];
			mb_q     <= s_axis_tdata[IN_MB_LSB +: REG_W];
			mc_q     <= s_axis_tdata[IN_MC_LSB +: REG_W];
		end
		if (state_q == S_PREP) begin
			row_step_q <= RS_W'(stride_q) * RS_W'(eb_q);
		end
		if (state_q == S_RD_A) begin
			aw_q <= rd_w;
			ah_q <= rd_h;
		end
		if (state_q == S_RD_B) begin
			bw_q <= rd_w;
			bh_q <= rd_h;
		end
	end

	// one read port on the tile shape registers; register three reads as empty
	always_comb begin
		priority case (state_q)
			S_RD_A:  rd_idx = ma_q;
			S_RD_B:  rd_idx = mb_q;
			default: rd_idx = mc_q;
		endcase
		rd_w = '0;
		rd_h = '0;
		if (rd_idx < REG_W'(NUM_TREGS)) begin
			rd_w = reg_w_q[rd_idx];
			rd_h = reg_h_q[rd_idx];
		end
	end

	always_comb begin
		priority case (treg_q)
			TREG_A:  begin exp_w = inner_k_q; exp_h = rows_m_q; end
			TREG_B:  begin exp_w = cols_n_q;  exp_h = inner_k_q; end
			default: begin exp_w = cols_n_q;  exp_h = rows_m_q; end
		endcase
	end

	assign mac_bad = (aw_q != bh_q) || (rd_h != ah_q) || (rd_w != bw_q);
	assign ls_bad  = (op_q == OP_LOAD || op_q == OP_STORE) && check_en_q
		&& !(w_q == DIM_W'(1) && h_q == DIM_W'(1))
		&& (treg_q < REG_W'(NUM_TREGS))
		&& (w_q != exp_w || h_q != exp_h);
	assign status_item = (op_q == OP_MAC) || ls_bad || (w_q == '0) || (h_q == '0);
	assign rec_ok = (op_q == OP_LOAD) && !ls_bad && (treg_q < REG_W'(NUM_TREGS));

	always_comb begin
		if (op_q == OP_MAC) begin
			st_code = mac_bad ? ST_MAC_SHAPE : ST_OK;
		end else if (ls_bad) begin
			st_code = ST_SHAPE;
		end else begin
			st_code = ST_OK;
		end
	end

	always_comb begin
		state_d  = state_q;
		wctl     = '0;
		out_load = 1'b0;
		rec_en   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (op_t'(s_axis_tuser[1:0]) == OP_MAC) ? S_RD_A : S_PREP;
				end
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: state_d = S_PREP;
			S_PREP: begin
				wctl.start = 1'b1;
				if (!status_item) begin
					rec_en  = rec_ok;
					state_d = S_WALK;
				end else if (out_free) begin
					out_load = 1'b1;
					rec_en   = rec_ok;
					state_d  = S_IDLE;
				end
			end
			S_WALK: begin
				if (out_free) begin
					out_load  = 1'b1;
					wctl.step = 1'b1;
					if (wstat.last_elem) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TREGS; i++) begin
				reg_w_q[i] <= '0;
				reg_h_q[i] <= '0;
			end
		end else if (rec_en) begin
			reg_w_q[treg_q] <= w_q;
			reg_h_q[treg_q] <= h_q;
		end
	end

	taag_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (wctl),
		.base     (base_q),
		.eb       (eb_q),
		.row_step (row_step_q),
		.tile_w   (w_q),
		.tile_h   (h_q),
		.addr     (walk_addr),
		.stat     (wstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_WALK) begin
				out_addr_q  <= walk_addr;
				out_bytes_q <= eb_q;
				out_wr_q    <= (op_q == OP_STORE);
				out_acc_q   <= 1'b1;
				out_st_q    <= ST_OK;
				out_last_q  <= wstat.last_elem;
			end else begin
				out_addr_q  <= '0;
				out_bytes_q <= '0;
				out_wr_q    <= 1'b0;
				out_acc_q   <= 1'b0;
				out_st_q    <= st_code;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_bytes_q, out_addr_q});
	assign m_axis_tuser  = {out_st_q, out_acc_q, out_wr_q};
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_PREP) |-> !s_axis_tready)
		else $error("input taken during a walk");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[1]) |-> m_axis_tlast)
		else $error("status beat without tlast");

	a_access_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[3:2] == ST_OK))
		else $error("access beat with error status");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && out_free && wstat.last_elem) |=> (state_q == S_IDLE))
		else $error("walk did not end after last element");
`endif

endmodule

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import taag_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_TICKS = 20;

	typedef struct {
		op_t                 op;
		logic [ADDR_BITS-1:0] base;
		logic [DIM_W-1:0]    w;
		logic [DIM_W-1:0]    h;
		logic [STRIDE_W-1:0] stride;
		logic [EB_W-1:0]     eb;
		logic [REG_W-1:0]    treg;
		logic [REG_W-1:0]    ra;
		logic [REG_W-1:0]    rb;
		logic [REG_W-1:0]    rc;
	} tile_instr_t;

	typedef struct {
		logic [ADDR_BITS-1:0] addr;
		logic [EB_W-1:0]      nbytes;
		logic                 wr;
		logic                 acc;
		logic [1:0]           st;
		logic                 tl;
	} access_beat_t;

	class access_stream_checker;
		logic             check_en;
		logic [DIM_W-1:0] rows_m;
		logic [DIM_W-1:0] cols_n;
		logic [DIM_W-1:0] inner_k;
		logic [DIM_W-1:0] shape_w[NUM_TREGS];
		logic [DIM_W-1:0] shape_h[NUM_TREGS];
		access_beat_t     pending_beats[$];
		int unsigned      fails;

		function new();
			check_en = 1'b0;
			rows_m   = DIM_W'(MAX_TILE_DIM);
			cols_n   = DIM_W'(MAX_TILE_DIM);
			inner_k  = DIM_W'(MAX_TILE_DIM);
			for (int i = 0; i < NUM_TREGS; i++) begin
				shape_w[i] = '0;
				shape_h[i] = '0;
			end
			fails = 0;
		endfunction

		function void set_cfg(logic [1:0] idx, logic [DIM_W-1:0] val);
			case (idx)
				CFG_CHECK_EN: check_en = val[0];
				CFG_ROWS_M:   rows_m   = val;
				CFG_COLS_N:   cols_n   = val;
				CFG_INNER_K:  inner_k  = val;
				default: ;
			endcase
		endfunction

		function int unsigned clip_dim(logic [DIM_W-1:0] v);
			return (v > MAX_TILE_DIM) ? MAX_TILE_DIM : int'(v);
		endfunction

		function void shape_of(logic [REG_W-1:0] r, output int unsigned w, output int unsigned h);
			if (r < NUM_TREGS) begin
				w = shape_w[r];
				h = shape_h[r];
			end else begin
				w = 0;
				h = 0;
			end
		endfunction

		function void push_status(status_t s);
			access_beat_t b;
			b.addr   = '0;
			b.nbytes = '0;
			b.wr     = 1'b0;
			b.acc    = 1'b0;
			b.st     = s;
			b.tl     = 1'b1;
			pending_beats.push_back(b);
		endfunction

		function void note_instr(tile_instr_t ins);
			int unsigned w, h, eb, ew, eh, aw, ah, bw, bh, cw, ch;
			logic [63:0] off;
			access_beat_t b;
			w  = clip_dim(ins.w);
			h  = clip_dim(ins.h);
			eb = (ins.eb > MAX_EB) ? MAX_EB : int'(ins.eb);
			if (ins.op == OP_MAC) begin
				shape_of(ins.ra, aw, ah);
				shape_of(ins.rb, bw, bh);
				shape_of(ins.rc, cw, ch);
				push_status((aw != bh || ch != ah || cw != bw) ? ST_MAC_SHAPE : ST_OK);
				return;
			end
			// 1x1 tiles and the unnamed fourth register bypass the shape check
			if (ins.op != OP_PREFETCH && check_en && !(w == 1 && h == 1) &&
			    ins.treg < NUM_TREGS) begin
				case (ins.treg)
					TREG_A: begin ew = inner_k; eh = rows_m; end
					TREG_B: begin ew = cols_n;  eh = inner_k; end
					default: begin ew = cols_n; eh = rows_m; end
				endcase
				if (w != ew || h != eh) begin
					push_status(ST_SHAPE);
					return;
				end
			end
			if (ins.op == OP_LOAD && ins.treg < NUM_TREGS) begin
				shape_w[ins.treg] = DIM_W'(w);
				shape_h[ins.treg] = DIM_W'(h);
			end
			if (w == 0 || h == 0) begin
				push_status(ST_OK);
				return;
			end
			for (int unsigned r = 0; r < h; r++) begin
				for (int unsigned c = 0; c < w; c++) begin
					off      = (64'(r) * 64'(ins.stride) + 64'(c)) * 64'(eb);
					b.addr   = ADDR_BITS'(64'(ins.base) + off);
					b.nbytes = EB_W'(eb);
					b.wr     = (ins.op == OP_STORE);
					b.acc    = 1'b1;
					b.st     = ST_OK;
					b.tl     = (r + 1 == h && c + 1 == w);
					pending_beats.push_back(b);
				end
			end
		endfunction

		function void cmp_field(string field, logic [ADDR_BITS-1:0] want,
		                        logic [ADDR_BITS-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				fails++;
			end
		endfunction

		function void check_beat(access_beat_t got);
			access_beat_t want;
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: addr %0h bytes %0d", got.addr, got.nbytes);
				fails++;
				return;
			end
			want = pending_beats.pop_front();
			cmp_field("access_address", want.addr, got.addr);
			cmp_field("access_bytes", ADDR_BITS'(want.nbytes), ADDR_BITS'(got.nbytes));
			cmp_field("is_write", ADDR_BITS'(want.wr), ADDR_BITS'(got.wr));
			cmp_field("is_access", ADDR_BITS'(want.acc), ADDR_BITS'(got.acc));
			cmp_field("status", ADDR_BITS'(want.st), ADDR_BITS'(got.st));
			cmp_field("last", ADDR_BITS'(want.tl), ADDR_BITS'(got.tl));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	logic [IN_USER_W-1:0]   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [OUT_USER_W-1:0]  m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CFG_ADDR_W-1:0]  paddr;
	logic [CFG_DATA_W-1:0]  pwdata;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	access_stream_checker accesses = new();

	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned hold_token     = 0;
	int unsigned hold_seen      = 0;
	int unsigned hold_left      = 0;

	tile_access_address_generator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		access_beat_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.addr   = m_axis_tdata[ADDR_BITS-1:0];
			got.nbytes = m_axis_tdata[ADDR_BITS +: EB_W];
			got.wr     = m_axis_tuser[0];
			got.acc    = m_axis_tuser[1];
			got.st     = m_axis_tuser[3:2];
			got.tl     = m_axis_tlast;
			accesses.check_beat(got);
		end
	end

	function automatic tile_instr_t mk(op_t op, logic [ADDR_BITS-1:0] base,
	                                   logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
	                                   logic [STRIDE_W-1:0] stride, logic [EB_W-1:0] eb,
	                                   logic [REG_W-1:0] treg, logic [REG_W-1:0] ra,
	                                   logic [REG_W-1:0] rb, logic [REG_W-1:0] rc);
		tile_instr_t t;
		t.op     = op;
		t.base   = base;
		t.w      = w;
		t.h      = h;
		t.stride = stride;
		t.eb     = eb;
		t.treg   = treg;
		t.ra     = ra;
		t.rb     = rb;
		t.rc     = rc;
		return t;
	endfunction

	// mostly shapes that fit the configured dimensions, so checks and MACs pass
	function automatic tile_instr_t rand_instr();
		tile_instr_t t;
		int unsigned pick;
		pick     = $urandom_range(0, 99);
		t.op     = (pick < 35) ? OP_LOAD : (pick < 60) ? OP_STORE :
		           (pick < 75) ? OP_PREFETCH : OP_MAC;
		t.base   = ADDR_BITS'({$urandom, $urandom});
		t.stride = ($urandom_range(0, 99) < 30) ? STRIDE_W'($urandom) :
		           STRIDE_W'($urandom_range(0, 20));
		t.eb     = ($urandom_range(0, 99) < 20) ? EB_W'($urandom) :
		           EB_W'(1 << $urandom_range(0, 6));
		t.treg   = ($urandom_range(0, 9) == 0) ? REG_W'(3) : REG_W'($urandom_range(0, 2));
		if ($urandom_range(0, 99) < 70) begin
			t.ra = TREG_A;
			t.rb = TREG_B;
			t.rc = TREG_C;
		end else begin
			t.ra = REG_W'($urandom_range(0, 3));
			t.rb = REG_W'($urandom_range(0, 3));
			t.rc = REG_W'($urandom_range(0, 3));
		end
		if ($urandom_range(0, 99) < 65) begin
			case (t.treg)
				TREG_A: begin t.w = accesses.inner_k; t.h = accesses.rows_m; end
				TREG_B: begin t.w = accesses.cols_n; t.h = accesses.inner_k; end
				default: begin t.w = accesses.cols_n; t.h = accesses.rows_m; end
			endcase
		end else begin
			t.w = DIM_W'($urandom_range(0, 15));
			t.h = DIM_W'($urandom_range(0, 15));
		end
		return t;
	endfunction

	task automatic send_instr(tile_instr_t ins);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[IN_BASE_LSB +: ADDR_BITS] = ins.base;
		d[IN_W_LSB +: DIM_W]        = ins.w;
		d[IN_H_LSB +: DIM_W]        = ins.h;
		d[IN_STRIDE_LSB +: STRIDE_W] = ins.stride;
		d[IN_EB_LSB +: EB_W]        = ins.eb;
		d[IN_TREG_LSB +: REG_W]     = ins.treg;
		d[IN_MA_LSB +: REG_W]       = ins.ra;
		d[IN_MB_LSB +: REG_W]       = ins.rb;
		d[IN_MC_LSB +: REG_W]       = ins.rc;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= ins.op;
		do @(posedge clk); while (!s_axis_tready);
		accesses.note_instr(ins);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (accesses.pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [DIM_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'({idx, 2'b00});
		pwdata  <= CFG_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		accesses.set_cfg(idx, val);
	endtask

	task automatic set_mode(logic ce, logic [DIM_W-1:0] m, logic [DIM_W-1:0] n,
	                        logic [DIM_W-1:0] k, int unsigned src_pct, int unsigned sink_pct);
		drain();
		apb_write(CFG_CHECK_EN, DIM_W'(ce));
		apb_write(CFG_ROWS_M, m);
		apb_write(CFG_COLS_N, n);
		apb_write(CFG_INNER_K, k);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	initial begin
		#4000000;
		$display("tile_access_address_generator verification failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_mode(1'b0, 4'd8, 4'd8, 4'd8, 0, 0);
		send_instr(mk(OP_LOAD, '0, 4'd1, 4'd1, 16'd0, 7'd1, TREG_A, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_LOAD, '1, 4'd8, 4'd8, 16'hFFFF, 7'd64, TREG_A, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_LOAD, 48'h1000, 4'd15, 4'd9, 16'd8, 7'd127, TREG_B, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_LOAD, 48'h2000, 4'd8, 4'd8, 16'd8, 7'd4, TREG_C, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_MAC, '0, 4'd0, 4'd0, 16'd0, 7'd0, TREG_A, TREG_A, TREG_B, TREG_C));
		send_instr(mk(OP_STORE, 48'h8000_0000_0000, 4'd4, 4'd3, 16'd0, 7'd2, TREG_B,
		              2'd3, 2'd3, 2'd3));
		send_instr(mk(OP_PREFETCH, 48'hFFFF_FFFF_FF00, 4'd8, 4'd2, 16'd100, 7'd0, TREG_A,
		              2'd0, 2'd0, 2'd0));
		// zero-width load still records its shape
		send_instr(mk(OP_LOAD, 48'h3000, 4'd0, 4'd5, 16'd4, 7'd8, TREG_C, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_MAC, '0, 4'd1, 4'd1, 16'd0, 7'd1, TREG_A, TREG_A, TREG_B, TREG_C));
		send_instr(mk(OP_LOAD, 48'h4000, 4'd2, 4'd2, 16'd2, 7'd8, 2'd3, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_MAC, '0, 4'd0, 4'd0, 16'd0, 7'd0, TREG_A, TREG_A, TREG_B, 2'd3));
		send_instr(mk(OP_STORE, 48'h5000, 4'd3, 4'd0, 16'd1, 7'd1, TREG_A, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_MAC, '0, 4'd0, 4'd0, 16'd0, 7'd0, TREG_A, 2'd3, 2'd3, 2'd3));

		set_mode(1'b1, 4'd3, 4'd5, 4'd2, 0, 0);
		send_instr(mk(OP_LOAD, 48'h100, 4'd2, 4'd3, 16'd2, 7'd4, TREG_A, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_LOAD, 48'h100, 4'd3, 4'd3, 16'd3, 7'd4, TREG_A, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_STORE, 48'h200, 4'd5, 4'd2, 16'd5, 7'd8, TREG_B, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_STORE, 48'h300, 4'd4, 4'd3, 16'd4, 7'd8, TREG_C, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_STORE, 48'h300, 4'd1, 4'd1, 16'd4, 7'd8, TREG_C, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_PREFETCH, 48'h400, 4'd7, 4'd7, 16'd9, 7'd1, TREG_A, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_LOAD, 48'h500, 4'd0, 4'd3, 16'd1, 7'd2, TREG_A, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_STORE, 48'h600, 4'd6, 4'd1, 16'd1, 7'd16, 2'd3, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_LOAD, 48'h700, 4'd5, 4'd2, 16'd5, 7'd2, TREG_B, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_LOAD, 48'h800, 4'd5, 4'd3, 16'd5, 7'd2, TREG_C, 2'd0, 2'd0, 2'd0));
		send_instr(mk(OP_MAC, '0, 4'd0, 4'd0, 16'd0, 7'd0, TREG_A, TREG_A, TREG_B, TREG_C));

		src_idle_pct = 87;
		repeat (50) send_instr(rand_instr());

		set_mode(1'b1, 4'd1, 4'd1, 4'd1, 0, 87);
		repeat (50) send_instr(rand_instr());

		set_mode(1'b0, 4'd8, 4'd8, 4'd8, 36, 36);
		repeat (45) send_instr(rand_instr());

		// long receiver hold-off with the sender pushing back to back
		set_mode(1'b1, 4'd8, 4'd4, 4'd6, 0, 0);
		hold_token = hold_token + 1;
		repeat (45) send_instr(rand_instr());

		drain();
		if (accesses.fails == 0 && accesses.pending_beats.size() == 0) begin
			$display("tile_access_address_generator verification clean");
		end else begin
			$display("tile_access_address_generator verification failed");
		end
		$finish;
	end

endmodule
